// File: rtl/core/assert_macros.svh
// assertion macros for the checker file rtks_chk.sv
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/rtks_pkg.sv
// types and constants for the running top-k sum block
// no dependencies
`default_nettype none

package rtks_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int SUM_W          = 38;
  localparam int COUNT_W        = 7;
  localparam int DEF_MAX_KEEP   = 64;
  localparam int DEF_VALUE_BITS = 32;
  localparam int FIFO_DEPTH     = 2;
  localparam logic [COUNT_W-1:0] KEEP_LIMIT_RST = 7'd8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                start_req;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   top_sum;
    logic [COUNT_W-1:0] kept_count;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/running_top_k_sum_top.sv
// running top-k sum: front config register and item trimming, item queue, back store and scan
// result: registered straight from the popped item while the store fills, else after a scan
// of the store over its one read port and a decide step; no new item is taken until it is popped
// reset: async active low; clears count, sum, queues, keep_limit to 8; store is not cleared
// depends on rtks_pkg, rtks_front, rtks_fifo, rtks_back
`default_nettype none

module running_top_k_sum_top #(
  parameter int MAX_KEEP   = rtks_pkg::DEF_MAX_KEEP,
  parameter int VALUE_BITS = rtks_pkg::DEF_VALUE_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rtks_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  wire rtks_pkg::in_item_t           item_i,
  input  wire logic                         push,
  output logic                              full,
  output rtks_pkg::out_item_t               result_o,
  output logic                              empty,
  input  wire logic                         pop
);
  import rtks_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  logic [VALUE_BITS:0] entry_in, entry_out;
  logic [CNT_W-1:0]    limit;
  logic                q_empty, q_pop;

  rtks_front #(.MAX_KEEP(MAX_KEEP), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .entry_o     (entry_in),
    .limit_o     (limit)
  );

  rtks_fifo #(.WIDTH(VALUE_BITS + 1), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (entry_out),
    .empty_o (q_empty)
  );

  rtks_back #(.MAX_KEEP(MAX_KEEP), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit),
    .entry_i       (entry_out),
    .entry_empty_i (q_empty),
    .entry_pop_o   (q_pop),
    .result_o      (result_o),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

`default_nettype wire

// File: rtl/core/rtks_front.sv
// front part: keep_limit register, limit cap and item trimming
// depends on rtks_pkg
`default_nettype none

module rtks_front #(
  parameter int MAX_KEEP   = 64,
  parameter int VALUE_BITS = 32,
  localparam int CNT_W     = $clog2(MAX_KEEP + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rtks_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  wire rtks_pkg::in_item_t         item_i,
  output logic [VALUE_BITS:0]             entry_o,
  output logic [CNT_W-1:0]                limit_o
);
  import rtks_pkg::*;

  localparam int LW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [COUNT_W-1:0] keep_limit_q;
  logic [LW-1:0]      limit_ext;
  logic [63:0]        sample_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_limit_q <= KEEP_LIMIT_RST;
    end else if (cfg_we_i) begin
      keep_limit_q <= cfg_wdata_i;
    end
  end

  // cap the limit at the store depth
  always_comb begin
    limit_ext = LW'(keep_limit_q);
    if (limit_ext > LW'(MAX_KEEP)) begin
      limit_o = CNT_W'(MAX_KEEP);
    end else begin
      limit_o = limit_ext[CNT_W-1:0];
    end
  end

  assign sample_ext = 64'(item_i.sample_value);
  assign entry_o    = {item_i.start_req, sample_ext[VALUE_BITS-1:0]};

endmodule

`default_nettype wire

// File: rtl/core/rtks_fifo.sv
// short item queue between front and back parts
// depends on no package; generic width and depth
`default_nettype none

module rtks_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == CW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtks_back.sv
// back part: value store, smallest-entry scan, running sum, result register
// depends on rtks_pkg
`default_nettype none

module rtks_back #(
  parameter int MAX_KEEP   = 64,
  parameter int VALUE_BITS = 32,
  localparam int CNT_W     = $clog2(MAX_KEEP + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [CNT_W-1:0]      limit_i,
  input  wire logic [VALUE_BITS:0]   entry_i,
  input  wire logic                  entry_empty_i,
  output logic                       entry_pop_o,
  output rtks_pkg::out_item_t        result_o,
  output logic                       empty,
  input  wire logic                  pop
);
  import rtks_pkg::*;

  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [VALUE_BITS-1:0] store_q [MAX_KEEP];
  logic [VALUE_BITS-1:0] rd_data_q;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic [VALUE_BITS-1:0] best_val_q, best_val_d;
  logic [CNT_W-1:0]      best_idx_q, best_idx_d;
  logic                  res_vld_q, res_vld_d;
  out_item_t             res_q, res_d;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic                  in_start;
  logic [VALUE_BITS-1:0] in_val;
  logic [CNT_W-1:0]      tot_eff;
  logic [SUM_W-1:0]      sum_eff;
  logic [63:0]           in_ext, val_ext, best_ext, cnt_ext;
  logic [SUM_W-1:0]      sum_new;

  assign in_start = entry_i[VALUE_BITS];
  assign in_val   = entry_i[VALUE_BITS-1:0];
  assign tot_eff  = in_start ? '0 : cnt_q;
  assign sum_eff  = in_start ? '0 : sum_q;
  assign in_ext   = 64'(in_val);
  assign val_ext  = 64'(val_q);
  assign best_ext = 64'(best_val_q);

  assign empty    = !res_vld_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    rd_data_q <= store_q[idx_q[AW-1:0]];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    val_d      = val_q;
    idx_d      = idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    res_vld_d  = res_vld_q && !pop;
    res_d      = res_q;
    entry_pop_o = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = tot_eff[AW-1:0];
    wr_data    = in_val;
    sum_new    = '0;
    cnt_ext    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (!entry_empty_i && !res_vld_q) begin
          entry_pop_o = 1'b1;
          if (tot_eff < limit_i) begin
            // store not full: append
            wr_en   = 1'b1;
            sum_new = sum_eff + in_ext[SUM_W-1:0];
            cnt_d   = tot_eff + CNT_W'(1);
            sum_d   = sum_new;
            cnt_ext = 64'(cnt_d);
            res_vld_d = 1'b1;
            res_d.top_sum    = sum_new;
            res_d.kept_count = cnt_ext[COUNT_W-1:0];
          end else if (tot_eff == '0) begin
            cnt_d   = tot_eff;
            sum_d   = sum_eff;
            cnt_ext = 64'(tot_eff);
            res_vld_d = 1'b1;
            res_d.top_sum    = sum_eff;
            res_d.kept_count = cnt_ext[COUNT_W-1:0];
          end else begin
            cnt_d   = tot_eff;
            sum_d   = sum_eff;
            val_d   = in_val;
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, its compare in the cycle after
        if (idx_q < cnt_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q;
          idx_d     = idx_q + CNT_W'(1);
        end
        if (cmp_vld_q) begin
          if (cmp_idx_q == '0 || rd_data_q < best_val_q) begin
            best_val_d = rd_data_q;
            best_idx_d = cmp_idx_q;
          end
        end else if (idx_q == cnt_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        sum_new = sum_q;
        if (best_val_q < val_q) begin
          wr_en   = 1'b1;
          wr_addr = best_idx_q[AW-1:0];
          wr_data = val_q;
          sum_new = sum_q - best_ext[SUM_W-1:0] + val_ext[SUM_W-1:0];
        end
        sum_d   = sum_new;
        cnt_ext = 64'(cnt_q);
        res_vld_d = 1'b1;
        res_d.top_sum    = sum_new;
        res_d.kept_count = cnt_ext[COUNT_W-1:0];
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      sum_q     <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    cmp_idx_q  <= cmp_idx_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/rtks_chk.sv
// port-level checker for running_top_k_sum_top, attached by bind
// depends on rtks_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rtks_chk #(
  parameter int MAX_KEEP = rtks_pkg::DEF_MAX_KEEP
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire rtks_pkg::out_item_t result_o,
  input wire logic                empty,
  input wire logic                pop
);
  import rtks_pkg::*;

  localparam int CHK_W = (COUNT_W > 12) ? COUNT_W : 12;

  logic [CHK_W-1:0] count_ext;
  assign count_ext = CHK_W'(result_o.kept_count);

  `AST_NXT(a_result_holds, !empty && !pop, !empty)
  `AST_NXT(a_result_stable, !empty && !pop, $stable(result_o))
  `AST_IMP(a_count_bound, !empty, count_ext <= CHK_W'(MAX_KEEP))
  // an empty store always has a zero sum
  `AST_IMP(a_zero_count_sum, !empty && result_o.kept_count == '0, result_o.top_sum == '0)

endmodule

bind running_top_k_sum_top rtks_chk #(.MAX_KEEP(MAX_KEEP)) u_rtks_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .result_o (result_o),
  .empty    (empty),
  .pop      (pop)
);

`default_nettype wire
